// ===== rtl/life_grid_generation_step_unit_defines.svh =====
// ----------------------------------------------------------------------------
// life grid step unit assertion macros
// shared assertion forms, sampled on clock and disabled during reset
// ----------------------------------------------------------------------------
`ifndef LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_UNIT_DEFINES_SVH

// same-cycle implication
`define LGS_ASSERT_SAME(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("lgs check failed");

// next-cycle implication
`define LGS_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("lgs check failed");

`endif

// ===== rtl/lgs_pkg.sv =====
// ----------------------------------------------------------------------------
// lgs_pkg
// item types and fixed codes of the life grid step unit
// ----------------------------------------------------------------------------
package lgs_pkg;

   localparam logic [1:0] REQ_WRITE = 2'd0;
   localparam logic [1:0] REQ_STEP  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;

   localparam logic [3:0] BIRTH_COUNT   = 4'd3;
   localparam logic [3:0] SURVIVE_COUNT = 4'd2;

   localparam int IDX_W  = 4;
   localparam int CELL_W = 16;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [IDX_W-1:0]  row_index;
      logic [CELL_W-1:0] row_cells;
   } lgs_req_item_type;

   typedef struct packed {
      logic [IDX_W-1:0]  out_row;
      logic [CELL_W-1:0] out_cells;
      logic              last_row;
   } lgs_rsp_item_type;

endpackage

// ===== rtl/lgs_ram.sv =====
// ----------------------------------------------------------------------------
// lgs_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module lgs_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lgs_row_rule.sv =====
// ----------------------------------------------------------------------------
// lgs_row_rule
// next generation of one row from the rows above, at and below it
// ----------------------------------------------------------------------------
module lgs_row_rule #(
   parameter int GRID_SIZE = 16
) (
   input  logic [GRID_SIZE-1:0] above_row,
   input  logic [GRID_SIZE-1:0] mid_row,
   input  logic [GRID_SIZE-1:0] below_row,
   output logic [GRID_SIZE-1:0] next_row
);

   logic [GRID_SIZE+1:0] above_pad;
   logic [GRID_SIZE+1:0] mid_pad;
   logic [GRID_SIZE+1:0] below_pad;

   // dead cells beyond both edges
   assign above_pad = {1'b0, above_row, 1'b0};
   assign mid_pad   = {1'b0, mid_row, 1'b0};
   assign below_pad = {1'b0, below_row, 1'b0};

   always_comb begin
      logic [3:0] nbr;
      next_row = '0;
      for (int c = 0; c < GRID_SIZE; c++) begin
         nbr = {3'b0, above_pad[c]} + {3'b0, above_pad[c+1]} + {3'b0, above_pad[c+2]}
             + {3'b0, mid_pad[c]} + {3'b0, mid_pad[c+2]}
             + {3'b0, below_pad[c]} + {3'b0, below_pad[c+1]} + {3'b0, below_pad[c+2]};
         next_row[c] = (nbr == lgs_pkg::BIRTH_COUNT)
                     || (mid_row[c] && (nbr == lgs_pkg::SURVIVE_COUNT));
      end
   end

endmodule

// ===== rtl/life_grid_generation_step_unit.sv =====
// ----------------------------------------------------------------------------
// life_grid_generation_step_unit
// game of life grid (b3/s23, dead border) held one row per ram entry
// ----------------------------------------------------------------------------
// req channel: a write item stores one row; rows at or
// beyond GRID_SIZE are dropped. a read item emits every row from row 0 up;
// a step item advances one generation and emits the new rows. the final row
// of a run carries last_row. request kind 3 is dropped.
// rsp channel: one registered item per row; a step fills its row window
// before its first row. rows then follow one per cycle while rsp_ready is high.
// req_ready stays low for the whole of a read or a step; the single ram read
// port, one row per cycle unless the output stalls, sets the run length.
// a step reads row r+1 while it writes the new row r-1, with rows r-2 and r-1
// held in a two-row window and row r at the ram output.
// reset: all cells read dead at once through one valid flag per row; there
// is no clearing pass. req_ready is high only between runs.
// a stalled rsp_ready holds the output register and pauses the ram reads;
// nothing is lost and the run resumes where it stopped.
// ----------------------------------------------------------------------------
module life_grid_generation_step_unit #(
   parameter int GRID_SIZE = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  lgs_pkg::lgs_req_item_type req_item,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output lgs_pkg::lgs_rsp_item_type rsp_item
);

   localparam int AW   = $clog2(GRID_SIZE);
   localparam int IW   = ((AW > lgs_pkg::IDX_W) ? AW : lgs_pkg::IDX_W) + 1;
   localparam int PADW = (GRID_SIZE > lgs_pkg::CELL_W) ? GRID_SIZE : lgs_pkg::CELL_W;
   localparam logic [AW-1:0] LAST_ROW = AW'(GRID_SIZE - 1);
   localparam logic [IW-1:0] ROW_LIMIT = IW'(GRID_SIZE);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EMIT,
      ST_STEP,
      ST_FLUSH
   } state_type;

   state_type                  state_ff, state_in;
   logic [AW-1:0]              cons_cnt_ff, cons_cnt_in;
   logic                       have_ff, have_in;
   logic                       vmask_ff, vmask_in;
   logic [GRID_SIZE-1:0]       valid_ff, valid_in;
   logic [GRID_SIZE-1:0]       above_ff, above_in;
   logic [GRID_SIZE-1:0]       mid_ff, mid_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   lgs_pkg::lgs_rsp_item_type  rsp_item_ff, rsp_item_in;

   logic                       wr_en;
   logic [AW-1:0]              wr_addr;
   logic [GRID_SIZE-1:0]       wr_data;
   logic                       rd_en;
   logic [AW-1:0]              rd_addr;
   logic [GRID_SIZE-1:0]       rd_data;

   logic                       req_fire;
   logic                       out_free;
   logic                       consume;
   logic                       is_last;
   logic [GRID_SIZE-1:0]       ram_row;
   logic [GRID_SIZE-1:0]       below_row;
   logic [GRID_SIZE-1:0]       next_row;
   logic [IW-1:0]              req_idx_pad;
   logic [PADW-1:0]            req_cells_pad;
   logic [GRID_SIZE-1:0]       req_row;

   logic                       out_load;
   logic [AW-1:0]              out_idx;
   logic [GRID_SIZE-1:0]       out_data;
   logic                       out_last;
   logic [IW-1:0]              out_idx_pad;
   logic [PADW-1:0]            out_data_pad;

   lgs_ram #(
      .WIDTH (GRID_SIZE),
      .DEPTH (GRID_SIZE)
   ) u_grid_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lgs_row_rule #(
      .GRID_SIZE (GRID_SIZE)
   ) u_row_rule (
      .above_row (above_ff),
      .mid_row   (mid_ff),
      .below_row (below_row),
      .next_row  (next_row)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign is_last   = (cons_cnt_ff == LAST_ROW);
   assign consume   = ((state_ff == ST_EMIT) || (state_ff == ST_STEP)) && have_ff && out_free;

   // rows never written since reset read as dead
   assign ram_row   = vmask_ff ? rd_data : '0;
   assign below_row = (state_ff == ST_FLUSH) ? '0 : ram_row;

   assign req_idx_pad   = IW'(req_item.row_index);
   assign req_cells_pad = PADW'(req_item.row_cells);
   assign req_row       = req_cells_pad[GRID_SIZE-1:0];

   assign out_idx_pad  = IW'(out_idx);
   assign out_data_pad = PADW'(out_data);

   always_comb begin
      state_in     = state_ff;
      cons_cnt_in  = cons_cnt_ff;
      have_in      = have_ff;
      valid_in     = valid_ff;
      above_in     = above_ff;
      mid_in       = mid_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_item_in  = rsp_item_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      out_load     = 1'b0;
      out_idx      = '0;
      out_data     = '0;
      out_last     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_item.req_type)
                  lgs_pkg::REQ_WRITE: begin
                     if (req_idx_pad < ROW_LIMIT) begin
                        wr_en   = 1'b1;
                        wr_addr = req_idx_pad[AW-1:0];
                        wr_data = req_row;
                     end
                  end
                  lgs_pkg::REQ_STEP: begin
                     rd_en       = 1'b1;
                     have_in     = 1'b1;
                     cons_cnt_in = '0;
                     mid_in      = '0;
                     state_in    = ST_STEP;
                  end
                  lgs_pkg::REQ_READ: begin
                     rd_en       = 1'b1;
                     have_in     = 1'b1;
                     cons_cnt_in = '0;
                     state_in    = ST_EMIT;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_EMIT: begin
            if (consume) begin
               out_load = 1'b1;
               out_idx  = cons_cnt_ff;
               out_data = ram_row;
               out_last = is_last;
               if (is_last) begin
                  have_in  = 1'b0;
                  state_in = ST_IDLE;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = cons_cnt_ff + AW'(1);
                  cons_cnt_in = cons_cnt_ff + AW'(1);
               end
            end
         end
         ST_STEP: begin
            if (consume) begin
               above_in = mid_ff;
               mid_in   = ram_row;
               // first row only fills the window
               if (cons_cnt_ff != '0) begin
                  wr_en    = 1'b1;
                  wr_addr  = cons_cnt_ff - AW'(1);
                  wr_data  = next_row;
                  out_load = 1'b1;
                  out_idx  = cons_cnt_ff - AW'(1);
                  out_data = next_row;
               end
               if (is_last) begin
                  have_in  = 1'b0;
                  state_in = ST_FLUSH;
               end else begin
                  rd_en       = 1'b1;
                  rd_addr     = cons_cnt_ff + AW'(1);
                  cons_cnt_in = cons_cnt_ff + AW'(1);
               end
            end
         end
         ST_FLUSH: begin
            if (out_free) begin
               wr_en    = 1'b1;
               wr_addr  = LAST_ROW;
               wr_data  = next_row;
               out_load = 1'b1;
               out_idx  = LAST_ROW;
               out_data = next_row;
               out_last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end

      if (out_load) begin
         rsp_valid_in          = 1'b1;
         rsp_item_in.out_row   = out_idx_pad[lgs_pkg::IDX_W-1:0];
         rsp_item_in.out_cells = out_data_pad[lgs_pkg::CELL_W-1:0];
         rsp_item_in.last_row  = out_last;
      end
   end

   assign vmask_in = rd_en ? valid_ff[rd_addr] : vmask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cons_cnt_ff  <= '0;
         have_ff      <= 1'b0;
         vmask_ff     <= 1'b0;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cons_cnt_ff  <= cons_cnt_in;
         have_ff      <= have_in;
         vmask_ff     <= vmask_in;
         valid_ff     <= valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      above_ff    <= above_in;
      mid_ff      <= mid_in;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/lgs_checker.sv =====
// ----------------------------------------------------------------------------
// lgs_checker
// port level checks of the life grid step unit, bound to the top level
// ----------------------------------------------------------------------------
`include "life_grid_generation_step_unit_defines.svh"

module lgs_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input lgs_pkg::lgs_rsp_item_type rsp_item
);

   // stalled item holds
   `LGS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_item))

   // no new request while a run is still emitting
   `LGS_ASSERT_SAME(a_busy_in_run, rsp_valid && !rsp_item.last_row, !req_ready)

   // rows of a run follow back to back
   `LGS_ASSERT_NEXT(a_run_no_gap, rsp_valid && rsp_ready && !rsp_item.last_row, rsp_valid)

   // rows of a run count up by one
   `LGS_ASSERT_NEXT(a_run_order, rsp_valid && rsp_ready && !rsp_item.last_row, rsp_item.out_row == $past(rsp_item.out_row) + 4'd1)

   // a new run starts at row zero
   `LGS_ASSERT_NEXT(a_run_start, rsp_valid && rsp_ready && rsp_item.last_row, !rsp_valid || (rsp_item.out_row == 4'd0))

endmodule

bind life_grid_generation_step_unit lgs_checker u_lgs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_item  (rsp_item)
);

// ===== test/life_grid_generation_step_unit_checker.sv =====
// ----------------------------------------------------------------------------
// life grid step unit checker
// watches both channels, keeps its own copy of the grid, works out the rows
// that each step or read must emit and compares every emitted item with them
// ----------------------------------------------------------------------------
module life_grid_generation_step_unit_checker #(
   parameter int GRID_N = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  lgs_pkg::lgs_req_item_type req_item,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  lgs_pkg::lgs_rsp_item_type rsp_item,
   output int                        rows_pending,
   output int                        fail_count
);

   typedef logic [GRID_N-1:0][lgs_pkg::CELL_W-1:0] grid_type;

   grid_type                  grid_now;
   lgs_pkg::lgs_rsp_item_type expected_rows[$];

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   // b3/s23 with dead cells beyond the border
   function automatic grid_type next_generation(input grid_type g);
      grid_type nxt;
      int       live;
      nxt = '0;
      for (int r = 0; r < GRID_N; r++) begin
         for (int c = 0; c < GRID_N; c++) begin
            live = 0;
            for (int dr = -1; dr <= 1; dr++) begin
               for (int dc = -1; dc <= 1; dc++) begin
                  if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_N &&
                      c + dc >= 0 && c + dc < GRID_N)
                     live = live + int'(g[r+dr][c+dc]);
               end
            end
            nxt[r][c] = (live == 3) || (g[r][c] && live == 2);
         end
      end
      return nxt;
   endfunction

   task automatic queue_grid_rows();
      lgs_pkg::lgs_rsp_item_type row_item;
      for (int r = 0; r < GRID_N; r++) begin
         row_item.out_row   = r[lgs_pkg::IDX_W-1:0];
         row_item.out_cells = grid_now[r];
         row_item.last_row  = (r == GRID_N - 1);
         expected_rows.push_back(row_item);
      end
   endtask

   always @(posedge clock) begin
      lgs_pkg::lgs_rsp_item_type want;
      if (reset) begin
         grid_now = '0;
         expected_rows.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rows.size() == 0) begin
               report_mismatch($sformatf("row %0d item with nothing expected",
                                         rsp_item.out_row));
            end else begin
               want = expected_rows.pop_front();
               if (rsp_item.out_row !== want.out_row)
                  report_mismatch($sformatf("out_row got %0d expected %0d",
                                            rsp_item.out_row, want.out_row));
               if (rsp_item.out_cells !== want.out_cells)
                  report_mismatch($sformatf("row %0d out_cells got %h expected %h",
                                            want.out_row, rsp_item.out_cells,
                                            want.out_cells));
               if (rsp_item.last_row !== want.last_row)
                  report_mismatch($sformatf("row %0d last_row got %b expected %b",
                                            want.out_row, rsp_item.last_row,
                                            want.last_row));
            end
         end
         if (req_valid && req_ready) begin
            case (req_item.req_type)
               lgs_pkg::REQ_WRITE: begin
                  if (req_item.row_index < GRID_N)
                     grid_now[req_item.row_index] = req_item.row_cells;
               end
               lgs_pkg::REQ_STEP: begin
                  grid_now = next_generation(grid_now);
                  queue_grid_rows();
               end
               lgs_pkg::REQ_READ: begin
                  queue_grid_rows();
               end
               default: ;
            endcase
         end
      end
      rows_pending <= expected_rows.size();
   end

endmodule

// ===== test/life_grid_generation_step_unit_test.sv =====
// ----------------------------------------------------------------------------
// life grid step unit testbench
// drives row writes, steps, reads and dropped request kinds in random bursts
// against a randomly stalling receiver; the checker predicts and compares
// ----------------------------------------------------------------------------
module life_grid_generation_step_unit_test;

   localparam int GRID_N      = 16;
   localparam int ITEM_TARGET = 420;
   localparam int CYCLE_LIMIT = 500000;

   // request kind with no meaning, dropped by the block
   localparam logic [1:0] REQ_IGNORED = 2'd3;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      req_valid = 1'b0;
   lgs_pkg::lgs_req_item_type req_item  = '0;
   logic                      rsp_ready = 1'b0;
   logic                      req_ready;
   logic                      rsp_valid;
   lgs_pkg::lgs_rsp_item_type rsp_item;
   int                        rows_pending;
   int                        fail_count;
   int                        cycle_count = 0;
   int                        burst_left  = 0;
   int                        items_sent  = 0;
   int                        ready_mode  = 0;
   int                        ready_left  = 0;

   always #5 clock = ~clock;

   life_grid_generation_step_unit #(
      .GRID_SIZE(GRID_N)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_item (rsp_item)
   );

   life_grid_generation_step_unit_checker #(
      .GRID_N(GRID_N)
   ) checker_0 (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_item    (req_item),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_item    (rsp_item),
      .rows_pending(rows_pending),
      .fail_count  (fail_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("life_grid_generation_step_unit test failed");
         $finish;
      end
   end

   // receiver stall pattern, changes character after each stretch of random length
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_left = $urandom_range(8, 64);
      end
      ready_left--;
      case (ready_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= ~rsp_ready;
         default: rsp_ready <= ($urandom_range(0, 5) == 0);
      endcase
   end

   function automatic lgs_pkg::lgs_req_item_type make_req(input logic [1:0] kind,
                                                          input logic [3:0] idx,
                                                          input logic [15:0] cells);
      lgs_pkg::lgs_req_item_type it;
      it.req_type  = kind;
      it.row_index = idx;
      it.row_cells = cells;
      return it;
   endfunction

   function automatic logic [15:0] random_row();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return 16'($urandom & $urandom & $urandom);
         2, 3: return 16'($urandom & $urandom);
         4: return 16'($urandom);
         default: return 16'($urandom | $urandom);
      endcase
   endfunction

   task automatic send(input lgs_pkg::lgs_req_item_type it);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap = $urandom_range(0, 2);
            5, 6, 7, 8: gap = $urandom_range(3, 12);
            default: gap = $urandom_range(20, 60);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_item  <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (it.req_type != REQ_IGNORED)
         items_sent++;
   endtask

   task automatic wait_for_rows();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (rows_pending != 0);
   endtask

   initial begin
      int n_writes;
      int n_steps;
      bit full_load;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // empty grid, dropped kind, edge rows, glider, blinker and block
      send(make_req(lgs_pkg::REQ_READ, 4'h0, 16'h0000));
      send(make_req(REQ_IGNORED, 4'hf, 16'hffff));
      send(make_req(lgs_pkg::REQ_READ, 4'hf, 16'hffff));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h0, 16'hffff));
      send(make_req(lgs_pkg::REQ_WRITE, 4'hf, 16'hffff));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h7, 16'h8001));
      send(make_req(lgs_pkg::REQ_READ, 4'h5, 16'h5a5a));
      send(make_req(lgs_pkg::REQ_STEP, 4'ha, 16'ha5a5));
      send(make_req(lgs_pkg::REQ_STEP, 4'h0, 16'h0000));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h0, 16'h0000));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h1, 16'h0002));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h2, 16'h0004));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h3, 16'h0007));
      send(make_req(lgs_pkg::REQ_WRITE, 4'h7, 16'h0000));
      send(make_req(lgs_pkg::REQ_WRITE, 4'ha, 16'h7000));
      send(make_req(lgs_pkg::REQ_WRITE, 4'hc, 16'h0300));
      send(make_req(lgs_pkg::REQ_WRITE, 4'hd, 16'h0300));
      send(make_req(lgs_pkg::REQ_WRITE, 4'he, 16'h0000));
      send(make_req(lgs_pkg::REQ_WRITE, 4'hf, 16'h8000));
      send(make_req(lgs_pkg::REQ_STEP, 4'h3, 16'hffff));
      send(make_req(lgs_pkg::REQ_STEP, 4'hc, 16'h1234));
      send(make_req(lgs_pkg::REQ_STEP, 4'h6, 16'h0001));
      send(make_req(lgs_pkg::REQ_STEP, 4'h9, 16'h8000));
      send(make_req(lgs_pkg::REQ_READ, 4'h1, 16'hffff));
      send(make_req(REQ_IGNORED, 4'h0, 16'h0000));
      wait_for_rows();

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) < 7) begin
            // load some rows, then let the pattern evolve
            full_load = ($urandom_range(0, 3) == 0);
            n_writes  = full_load ? GRID_N : $urandom_range(1, GRID_N);
            for (int k = 0; k < n_writes; k++)
               send(make_req(lgs_pkg::REQ_WRITE,
                             full_load ? k[3:0] : 4'($urandom_range(0, GRID_N - 1)),
                             random_row()));
            n_steps = $urandom_range(1, 5);
            repeat (n_steps)
               send(make_req(lgs_pkg::REQ_STEP, 4'($urandom), 16'($urandom)));
            if ($urandom_range(0, 2) == 0)
               send(make_req(lgs_pkg::REQ_READ, 4'($urandom), 16'($urandom)));
         end else begin
            repeat ($urandom_range(1, 4))
               send(make_req(2'($urandom_range(0, 3)), 4'($urandom), 16'($urandom)));
         end
         if ($urandom_range(0, 24) == 0)
            wait_for_rows();
      end

      wait_for_rows();
      repeat (40) @(negedge clock);
      if (fail_count == 0)
         $display("life_grid_generation_step_unit test passed");
      else
         $display("life_grid_generation_step_unit test failed");
      $finish;
   end

endmodule
